// ===== design/vcm_pkg.sv =====
package vcm_pkg;

  localparam logic [31:0] OPAQUE    = 32'hFF000000;
  localparam logic [31:0] MISS_GREY = 32'h007F7F7F;
  localparam logic [31:0] CLEAR     = 32'h00000000;

  localparam logic [2:0] MODE_CLASSIC = 3'd0;
  localparam logic [2:0] MODE_HUE     = 3'd1;
  localparam logic [2:0] MODE_PO      = 3'd2;
  localparam logic [2:0] MODE_BR      = 3'd3;
  localparam logic [2:0] MODE_GREY    = 3'd4;
  localparam logic [2:0] MODE_MONO    = 3'd5;

  localparam logic [1:0] REG_SCALE_MODE = 2'd0;
  localparam logic [1:0] REG_BLUE_LEVEL = 2'd1;
  localparam logic [1:0] REG_RED_LEVEL  = 2'd2;

  // ff mask bit positions
  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

  typedef enum logic [1:0] {
    KIND_CLASSIC,
    KIND_TABLE,
    KIND_FIXED
  } out_kind_t;

  typedef enum logic [1:0] {
    VSEL_NONE,
    VSEL_RED,
    VSEL_GREEN,
    VSEL_BLUE
  } vsel_t;

  typedef struct packed {
    out_kind_t   kind;
    logic [31:0] fix_color;
    logic [2:0]  ff_mask;
    vsel_t       vsel;
    logic [2:0]  mode;
  } ctl_t;

  localparam logic [23:0] HUE_TAB [10] = '{
    24'h3333DD, 24'h3388DD, 24'h22CCDD, 24'h22CCBB, 24'h22DD88,
    24'h88DD22, 24'hBBCC22, 24'hDDCC22, 24'hDD8833, 24'hDD3333
  };
  localparam logic [23:0] PO_TAB [7] = '{
    24'h542788, 24'h998EC3, 24'hD8DAEB, 24'hF7F7F7,
    24'hFEE0B6, 24'hF1A340, 24'hB35806
  };
  localparam logic [23:0] BR_TAB [7] = '{
    24'h4575B4, 24'h91BFDB, 24'hE0F3F8, 24'hFFFFBF,
    24'hFEE090, 24'hFC8D59, 24'hD73027
  };
  localparam logic [23:0] GREY_TAB [7] = '{
    24'h000000, 24'h444444, 24'h777777, 24'hAAAAAA,
    24'hCCCCCC, 24'hEEEEEE, 24'hFFFFFF
  };

  function automatic logic [23:0] table_color(input logic [2:0] mode, input logic [3:0] idx);
    logic [23:0] c;
    c = 24'h000000;
    unique case (mode) inside
      MODE_HUE: if (idx < 4'd10) c = HUE_TAB[idx];
      MODE_PO:  if (idx < 4'd7) c = PO_TAB[idx[2:0]];
      MODE_BR:  if (idx < 4'd7) c = BR_TAB[idx[2:0]];
      MODE_GREY, MODE_MONO: if (idx < 4'd7) c = GREY_TAB[idx[2:0]];
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

// ===== design/value_to_colormap_rgb.sv =====
// false-color lookup: one scalar sample in, one 32-bit argb color out
//
// input channel: in_valid / in_stall with sample_value (signed, FRAC_BITS
// fraction bits) and sample_missing; a request is taken when in_valid is
// high and in_stall is low
// output channel: out_valid / out_stall with argb_color, same rule
// config channel: cfg_valid / cfg_ready, cfg_index 0 scale_mode, 1 blue_level,
// 2 red_level; cfg_ready is always high, other indexes are dropped; write only
// while no request is in flight
//
// five register stages: mirror, band select, ratio scaling, threshold compare,
// color assembly; out_valid is the valid bit of the last stage
// throughput is one request per cycle while out_stall is low, set by the
// fully pipelined datapath with no shared unit
// when out_stall is high the whole pipe holds; empty stages still fill, and
// in_stall rises only once every stage holds a request
// reset empties the pipe and loads scale_mode 1, blue_level 0, red_level 1.0
module value_to_colormap_rgb #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [17:0] sample_value,
  input  logic               sample_missing,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        argb_color,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  import vcm_pkg::*;

  localparam int STAGES = 5;
  // value width holds mirrored samples and levels with headroom
  localparam int VW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
  // band arithmetic works on values times twenty
  localparam int NW = VW + 5;
  // threshold compare needs room for the 150000 scale
  localparam int LW = NW + 20;

  // configuration registers
  logic [2:0]  scale_mode;
  logic [16:0] blue_level;
  logic [16:0] red_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_mode <= MODE_HUE;
      blue_level <= 17'd0;
      red_level  <= 17'h10000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCALE_MODE: scale_mode <= cfg_data[2:0];
        REG_BLUE_LEVEL: blue_level <= cfg_data;
        REG_RED_LEVEL:  red_level  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control: a stage loads when it is empty or the next one moves
  logic [STAGES-1:0] stage_valid;
  logic [STAGES-1:0] load;

  always_comb begin
    load[STAGES-1] = !stage_valid[STAGES-1] || !out_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      load[i] = !stage_valid[i] || load[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (load[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (load[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
    end
  end

  assign in_stall  = !load[0];
  assign out_valid = stage_valid[STAGES-1];

  // datapath
  logic signed [NW-1:0] num, den;
  ctl_t                 ctl2, ctl4;
  logic [14:0]          above;

  vcm_band #(
    .FRAC_BITS(FRAC_BITS),
    .VW(VW),
    .NW(NW)
  ) u_band (
    .clk           (clk),
    .load_s1       (load[0]),
    .load_s2       (load[1]),
    .sample_value  (sample_value),
    .sample_missing(sample_missing),
    .mode          (scale_mode),
    .blue_level    (blue_level),
    .red_level     (red_level),
    .num           (num),
    .den           (den),
    .ctl           (ctl2)
  );

  vcm_ratio #(
    .NW(NW),
    .LW(LW)
  ) u_ratio (
    .clk    (clk),
    .load_s3(load[2]),
    .load_s4(load[3]),
    .num    (num),
    .den    (den),
    .ctl_in (ctl2),
    .above  (above),
    .ctl_out(ctl4)
  );

  vcm_color u_color (
    .clk       (clk),
    .load_s5   (load[4]),
    .above     (above),
    .ctl       (ctl4),
    .argb_color(argb_color)
  );

  // back pressure reaches the input only through a full pipe
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&stage_valid && out_stall))
    else $error("input stalled with an empty stage");

  a_no_stall_free: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

// ===== design/vcm_band.sv =====
module vcm_band #(
  parameter int FRAC_BITS = 16,
  parameter int VW = 20,
  parameter int NW = 25
) (
  input  logic                  clk,
  input  logic                  load_s1,
  input  logic                  load_s2,
  input  logic signed [17:0]    sample_value,
  input  logic                  sample_missing,
  input  logic [2:0]            mode,
  input  logic [16:0]           blue_level,
  input  logic [16:0]           red_level,
  output logic signed [NW-1:0]  num,
  output logic signed [NW-1:0]  den,
  output vcm_pkg::ctl_t         ctl
);
  import vcm_pkg::*;

  logic signed [VW-1:0] f1, b1, r1;
  logic                 miss1;
  logic signed [VW-1:0] fs, bs, rs, one_v;

  // stage 1: missing detect and mirror when levels are swapped
  always_comb begin
    fs    = VW'(sample_value);
    bs    = $signed(VW'(blue_level));
    rs    = $signed(VW'(red_level));
    one_v = $signed(VW'(1) << FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (load_s1) begin
      miss1 <= sample_missing || (fs == -one_v);
      if (bs > rs) begin
        f1 <= one_v - fs;
        b1 <= one_v - bs;
        r1 <= one_v - rs;
      end else begin
        f1 <= fs;
        b1 <= bs;
        r1 <= rs;
      end
    end
  end

  // stage 2: band select and ratio operands
  logic signed [NW-1:0] fe, be, re, one_n, d, fx, bx, rx, gx;
  logic signed [NW-1:0] num_next, den_next;
  ctl_t ctl_next;
  logic hit;

  always_comb begin
    fe    = NW'(f1);
    be    = NW'(b1);
    re    = NW'(r1);
    one_n = $signed(NW'(1) << FRAC_BITS);
    d     = re - be;
    fx    = fe * NW'(10);
    bx    = be * NW'(10);
    rx    = re * NW'(10);
    gx    = bx + d;
    num_next = '0;
    den_next = NW'(1);
    hit      = 1'b1;
    ctl_next.kind      = KIND_FIXED;
    ctl_next.fix_color = CLEAR;
    ctl_next.ff_mask   = 3'b000;
    ctl_next.vsel      = VSEL_NONE;
    ctl_next.mode      = mode;
    if (mode == MODE_CLASSIC) begin
      if (fe >= 0 && fe < be) begin
        num_next = be - fe;
        den_next = be * NW'(2);
        ctl_next.ff_mask[CH_BLUE] = 1'b1;
        ctl_next.vsel = VSEL_RED;
      end else if (fe >= be && fx * NW'(2) < gx + bx) begin
        num_next = (fx - bx) * NW'(2);
        den_next = d;
        ctl_next.ff_mask[CH_BLUE] = 1'b1;
        ctl_next.vsel = VSEL_GREEN;
      end else if (fx * NW'(2) >= gx + bx && fx < gx) begin
        num_next = (gx - fx) * NW'(2);
        den_next = d;
        ctl_next.ff_mask[CH_GREEN] = 1'b1;
        ctl_next.vsel = VSEL_BLUE;
      end else if (fx >= gx && fx * NW'(2) < gx + rx) begin
        num_next = (fx - gx) * NW'(2);
        den_next = rx - gx;
        ctl_next.ff_mask[CH_GREEN] = 1'b1;
        ctl_next.vsel = VSEL_RED;
      end else if (fx * NW'(2) >= gx + rx && fe < re) begin
        num_next = (rx - fx) * NW'(2);
        den_next = rx - gx;
        ctl_next.ff_mask[CH_RED] = 1'b1;
        ctl_next.vsel = VSEL_GREEN;
      end else if (fe >= re) begin
        num_next = fe - re;
        den_next = (one_n - re) * NW'(2);
        ctl_next.ff_mask[CH_RED] = 1'b1;
        ctl_next.vsel = VSEL_BLUE;
      end else begin
        hit = 1'b0;
      end
      if (hit) begin
        ctl_next.kind = KIND_CLASSIC;
      end else begin
        ctl_next.fix_color = OPAQUE;
      end
    end else if (mode <= MODE_MONO) begin
      ctl_next.kind = KIND_TABLE;
      num_next = fe - be;
      den_next = d;
      // equal levels: half at the level, else a step
      if (d == 0) begin
        if (num_next == 0) begin
          num_next = NW'(1);
          den_next = NW'(2);
        end else begin
          num_next = (num_next > 0) ? NW'(1) : NW'(0);
          den_next = NW'(1);
        end
      end
    end
    if (miss1) begin
      ctl_next.kind      = KIND_FIXED;
      ctl_next.fix_color = (mode == MODE_GREY || mode == MODE_MONO) ? CLEAR : MISS_GREY;
    end
  end

  always_ff @(posedge clk) begin
    if (load_s2) begin
      num <= num_next;
      den <= den_next;
      ctl <= ctl_next;
    end
  end

endmodule

// ===== design/vcm_ratio.sv =====
module vcm_ratio #(
  parameter int NW = 25,
  parameter int LW = 45
) (
  input  logic                  clk,
  input  logic                  load_s3,
  input  logic                  load_s4,
  input  logic signed [NW-1:0]  num,
  input  logic signed [NW-1:0]  den,
  input  vcm_pkg::ctl_t         ctl_in,
  output logic [14:0]           above,
  output vcm_pkg::ctl_t         ctl_out
);
  import vcm_pkg::*;

  // stage 3: scaled numerator and step size; count of k with lhs > k*step is the level
  logic signed [LW-1:0] nl, dl, lhs_next, step_next, lhs, step;
  logic [3:0] kmax_next, kmax;
  ctl_t ctl3;

  always_comb begin
    nl = LW'(num);
    dl = LW'(den);
    if (ctl_in.kind == KIND_TABLE) begin
      kmax_next = (ctl_in.mode == MODE_HUE) ? 4'd9 : 4'd6;
      lhs_next  = nl * ((ctl_in.mode == MODE_HUE) ? LW'(10) : LW'(7));
      step_next = dl;
    end else begin
      kmax_next = 4'd15;
      if (dl < 0) begin
        nl = -nl;
        dl = -dl;
      end
      if (dl == 0) begin
        lhs_next  = (nl > 0) ? LW'(16) : LW'(0);
        step_next = LW'(1);
      end else begin
        // floor(15*(n/d + 0.0333)) >= k  <=>  150000n + 4995d + 1 > 10000kd
        lhs_next  = nl * LW'(150000) + dl * LW'(4995) + LW'(1);
        step_next = dl * LW'(10000);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_s3) begin
      lhs  <= lhs_next;
      step <= step_next;
      kmax <= kmax_next;
      ctl3 <= ctl_in;
    end
  end

  // stage 4: one threshold compare per level
  logic [14:0] above_next;

  always_comb begin
    for (int k = 1; k <= 15; k++) begin
      above_next[k-1] = (4'(k) <= kmax) && (lhs > step * LW'(k));
    end
  end

  always_ff @(posedge clk) begin
    if (load_s4) begin
      above   <= above_next;
      ctl_out <= ctl3;
    end
  end

endmodule

// ===== design/vcm_color.sv =====
module vcm_color (
  input  logic           clk,
  input  logic           load_s5,
  input  logic [14:0]    above,
  input  vcm_pkg::ctl_t  ctl,
  output logic [31:0]    argb_color
);
  import vcm_pkg::*;

  logic [3:0]  level;
  logic [7:0]  vbyte;
  logic [7:0]  rc, gc, bc;
  logic [31:0] color_next;

  always_comb begin
    level = 4'($countones(above));
    vbyte = {level, level};
    rc = ctl.ff_mask[CH_RED]   ? 8'hFF : ((ctl.vsel == VSEL_RED)   ? vbyte : 8'h00);
    gc = ctl.ff_mask[CH_GREEN] ? 8'hFF : ((ctl.vsel == VSEL_GREEN) ? vbyte : 8'h00);
    bc = ctl.ff_mask[CH_BLUE]  ? 8'hFF : ((ctl.vsel == VSEL_BLUE)  ? vbyte : 8'h00);
    case (ctl.kind)
      KIND_CLASSIC: color_next = OPAQUE | {8'h00, rc, gc, bc};
      KIND_TABLE:   color_next = OPAQUE | {8'h00, table_color(ctl.mode, level)};
      default:      color_next = ctl.fix_color;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_s5) begin
      argb_color <= color_next;
    end
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  import vcm_pkg::*;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // dut ports, all inputs driven to known values from time zero
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [17:0] sample_value = '0;
  logic               sample_missing = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        argb_color;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [16:0]        cfg_data = '0;

  value_to_colormap_rgb u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_value(sample_value), .sample_missing(sample_missing),
    .out_valid(out_valid), .out_stall(out_stall), .argb_color(argb_color),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam longint ONE = 64'sd65536;
  localparam int CYCLE_LIMIT = 300000;
  // index with no register behind it
  localparam logic [1:0] REG_NONE = 2'd3;
  // mode codes with no meaning
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [17:0] value;
    logic               missing;
  } sample_req_t;

  // shadow copy of the configuration registers
  logic [2:0]  mode_q = MODE_HUE;
  logic [16:0] blue_q = 17'd0;
  logic [16:0] red_q  = 17'd65536;

  sample_req_t pending_samples[$];
  logic [31:0] colors_due[$];
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          errors = 0;
  int          cycles = 0;
  logic        hold_go = 1'b0;
  int          hold_cnt = 0;
  sample_req_t next_req;

  // 16-step channel quantization, (t + 0.0333) * 15 in exact integers
  function automatic logic [7:0] chan_level(longint num, longint den);
    longint x, q;
    if (den == 0) return (num > 0) ? 8'hFF : 8'h00;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    x = 15 * (10000 * num + 333 * den);
    if (x < 0) return 8'h00;
    q = x / (10000 * den);
    if (q > 15) q = 15;
    return q[7:0] * 8'h11;
  endfunction

  // ratio num/den clamped to 0..1, then entry ceil(f*n)-1
  function automatic int table_slot(longint num, longint den, longint n);
    if (num <= 0) return 0;
    if (num >= den) return int'(n - 1);
    return int'((num * n + den - 1) / den - 1);
  endfunction

  // six-band ramp
  function automatic logic [31:0] ramp_color(longint f, longint b, longint r);
    longint d, ff, bb, rr, gg;
    logic [7:0] rc, gc, bc;
    d = r - b;
    ff = 10 * f;
    bb = 10 * b;
    rr = 10 * r;
    gg = 10 * b + d;
    rc = 0;
    gc = 0;
    bc = 0;
    if (f >= 0 && f < b) begin
      rc = chan_level(b - f, 2 * b);
      bc = 8'hFF;
    end else if (f >= b && 2 * ff < gg + bb) begin
      bc = 8'hFF;
      gc = chan_level(2 * (ff - bb), d);
    end else if (2 * ff >= gg + bb && ff < gg) begin
      bc = chan_level(2 * (gg - ff), d);
      gc = 8'hFF;
    end else if (ff >= gg && 2 * ff < gg + rr) begin
      gc = 8'hFF;
      rc = chan_level(2 * (ff - gg), rr - gg);
    end else if (2 * ff >= gg + rr && f < r) begin
      gc = chan_level(2 * (rr - ff), rr - gg);
      rc = 8'hFF;
    end else if (f >= r) begin
      rc = 8'hFF;
      bc = chan_level(f - r, 2 * (ONE - r));
    end
    return OPAQUE | {8'h00, rc, gc, bc};
  endfunction

  function automatic logic [31:0] predict_color(logic signed [17:0] value, logic missing);
    longint f, b, r, num, den;
    f = value;
    b = blue_q;
    r = red_q;
    // missing sample: nan flag or exactly -1.0
    if (missing || f == -ONE)
      return (mode_q == MODE_GREY || mode_q == MODE_MONO) ? CLEAR : MISS_GREY;
    // inverted levels mirror everything
    if (b > r) begin
      f = ONE - f;
      b = ONE - b;
      r = ONE - r;
    end
    if (mode_q == MODE_CLASSIC) return ramp_color(f, b, r);
    num = f - b;
    den = r - b;
    // equal levels: 0.5 on the level, else a step
    if (den == 0) begin
      if (num == 0) begin
        num = 1;
        den = 2;
      end else begin
        num = (num > 0) ? 1 : 0;
        den = 1;
      end
    end
    case (mode_q) inside
      MODE_HUE: return OPAQUE | {8'h00, HUE_TAB[table_slot(num, den, 10)]};
      MODE_PO:  return OPAQUE | {8'h00, PO_TAB[table_slot(num, den, 7)]};
      MODE_BR:  return OPAQUE | {8'h00, BR_TAB[table_slot(num, den, 7)]};
      MODE_GREY, MODE_MONO: return OPAQUE | {8'h00, GREY_TAB[table_slot(num, den, 7)]};
      default:  return CLEAR;  // codes six and seven are unused
    endcase
  endfunction

  // driver: predicts at accept, then offers the next pending request
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        colors_due.insert(colors_due.size(), predict_color(sample_value, sample_missing));
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_samples.pop_front();
          in_valid <= 1'b1;
          sample_value <= next_req.value;
          sample_missing <= next_req.missing;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off counter for the receiver
  always @(posedge clk) begin
    if (hold_go) hold_cnt <= 300;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  // monitor: compare against the oldest prediction, then pick next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (colors_due.size() == 0) begin
        $error("argb_color: unexpected result %h", argb_color);
        errors++;
      end else if (colors_due[0] !== argb_color) begin
        $error("argb_color: expected %h actual %h", colors_due[0], argb_color);
        errors++;
        void'(colors_due.pop_front());
      end else begin
        void'(colors_due.pop_front());
      end
    end
    out_stall <= (hold_cnt > 1) || ($urandom_range(99) < stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic add_sample(logic signed [17:0] v, logic m);
    sample_req_t s;
    s.value = v;
    s.missing = m;
    pending_samples.insert(pending_samples.size(), s);
  endtask

  // waits until the pipe is drained
  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || colors_due.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // writes all three registers back to back, then an unused index, valid held high throughout
  task automatic load_levels(logic [2:0] m, logic [16:0] b, logic [16:0] r);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SCALE_MODE;
    cfg_data <= {14'd0, m};
    do @(posedge clk); while (!cfg_ready);
    mode_q = m;
    cfg_index <= REG_BLUE_LEVEL;
    cfg_data <= b;
    do @(posedge clk); while (!cfg_ready);
    blue_q = b;
    cfg_index <= REG_RED_LEVEL;
    cfg_data <= r;
    do @(posedge clk); while (!cfg_ready);
    red_q = r;
    // unused index, must be dropped
    cfg_index <= REG_NONE;
    cfg_data <= 17'($urandom);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // half the samples near the levels, one band edge and 1.0, the rest random or at -1.0 and the range ends
  function automatic logic signed [17:0] pick_sample();
    longint g, off;
    off = longint'($urandom_range(64)) - 32;
    g = blue_q + (longint'(red_q) - longint'(blue_q)) / 10;
    case ($urandom_range(7))
      0: return 18'($urandom);
      1: return 18'(longint'(blue_q) + off);
      2: return 18'(longint'(red_q) + off);
      3: return 18'(g + off);
      4: return 18'($urandom_range(65536));
      5: return -18'sd65536;
      6: return $urandom_range(1) ? 18'sh20000 : 18'sh1FFFF;
      default: return 18'(ONE + off);
    endcase
  endfunction

  logic [2:0]  set_mode [16] = '{MODE_CLASSIC, MODE_CLASSIC, MODE_CLASSIC, MODE_CLASSIC,
                                 MODE_HUE, MODE_HUE, MODE_PO, MODE_BR,
                                 MODE_GREY, MODE_MONO, MODE_SPARE_LO, MODE_SPARE_HI,
                                 MODE_CLASSIC, MODE_PO, MODE_BR, MODE_HUE};
  logic [16:0] set_blue [16] = '{17'd0, 17'd16384, 17'd65536, 17'd40000, 17'd0,
                                 17'd30000, 17'd65536, 17'd20000, 17'd1000, 17'd50000,
                                 17'd0, 17'd0, 17'd30000, 17'd0, 17'd65536, 17'd12345};
  logic [16:0] set_red  [16] = '{17'd65536, 17'd50000, 17'd0, 17'd40000, 17'd0,
                                 17'd30000, 17'd65536, 17'd90000, 17'd60000, 17'd10000,
                                 17'd65536, 17'd65536, 17'd131071, 17'd131071,
                                 17'd131071, 17'd70000};

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, ten-step hue
    add_sample(18'sd0, 1'b0);
    add_sample(18'sd65536, 1'b0);
    add_sample(-18'sd65536, 1'b0);        // exact -1.0 is missing
    add_sample(18'sd1234, 1'b1);          // nan flag
    add_sample(18'sh20000, 1'b0);
    add_sample(18'sh1FFFF, 1'b0);
    add_sample(18'sd6554, 1'b0);
    add_sample(18'sd6553, 1'b0);
    add_sample(18'sd32768, 1'b0);
    drain();

    // directed: classic ramp, band edges and the top band at red 1.0
    load_levels(MODE_CLASSIC, 17'd0, 17'd65536);
    add_sample(-18'sd1, 1'b0);            // below zero and below blue
    add_sample(18'sd6554, 1'b0);
    add_sample(18'sd3277, 1'b0);
    add_sample(18'sd65536, 1'b0);         // equal to red, zero divisor
    add_sample(18'sd70000, 1'b0);         // above red, zero divisor
    add_sample(18'sh1FFFF, 1'b1);
    drain();
    load_levels(MODE_CLASSIC, 17'd10000, 17'd100000);
    add_sample(18'sd100000, 1'b0);        // top band, red above 1.0
    add_sample(18'sd5000, 1'b0);
    add_sample(-18'sd5, 1'b0);
    add_sample(-18'sd65536, 1'b0);
    drain();
    load_levels(MODE_GREY, 17'd30000, 17'd30000);  // equal levels
    add_sample(18'sd30000, 1'b0);
    add_sample(18'sd30001, 1'b0);
    add_sample(18'sd29999, 1'b0);
    add_sample(18'sd0, 1'b1);
    drain();

    // random phases over the settings list and the idle patterns
    for (int p = 0; p < 16; p++) begin
      load_levels(set_mode[p], set_blue[p], set_red[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 56; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      if (p == 4) begin
        // receiver holds off while the sender keeps offering
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      for (int k = 0; k < 110; k++) add_sample(pick_sample(), $urandom_range(9) == 0);
      drain();
    end

    // a few random level settings on top
    for (int p = 0; p < 4; p++) begin
      load_levels(3'($urandom_range(7)), 17'($urandom_range(65536)),
                  17'($urandom_range(131071)));
      send_idle_pct = 20;
      stall_pct = 20;
      for (int k = 0; k < 30; k++) add_sample(pick_sample(), $urandom_range(9) == 0);
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/vcm_pkg.sv
design/vcm_band.sv
design/vcm_ratio.sv
design/vcm_color.sv
design/value_to_colormap_rgb.sv
test/testbench.sv
